>>> src/i2cblm_pkg.sv
`timescale 1ns / 1ps

package i2cblm_pkg;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_ST_REL  = 4'd1,
        PH_ST_SDA  = 4'd2,
        PH_SP_SDA  = 4'd3,
        PH_SP_SCL  = 4'd4,
        PH_WR_LOW  = 4'd5,
        PH_WR_HIGH = 4'd6,
        PH_WA_LOW  = 4'd7,
        PH_WA_HIGH = 4'd8,
        PH_RD_LOW  = 4'd9,
        PH_RD_HIGH = 4'd10,
        PH_RA_LOW  = 4'd11,
        PH_RA_HIGH = 4'd12
    } phase_t;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    localparam logic [1:0] REG_BIT_DELAY   = 2'd0;
    localparam logic [1:0] REG_SETUP_DELAY = 2'd1;
    localparam logic [1:0] REG_WRITE_PAUSE = 2'd2;

    localparam logic [15:0] BIT_DELAY_RESET   = 16'd10;
    localparam logic [15:0] SETUP_DELAY_RESET = 16'd10;
    localparam int unsigned BITS_PER_BYTE     = 8;

    typedef struct packed {
        logic [15:0] bit_delay;
        logic [15:0] setup_delay;
        logic        write_pause_enable;
    } cfg_t;

    typedef struct packed {
        logic       cmd_valid;
        op_t        operation;
        logic [7:0] write_data;
        logic       more_follow;
        logic       sda_in;
    } tick_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       ack_seen;
        logic       done_res;
        logic       ready_res;
        logic       sda_drive_low;
        logic       scl_drive_low;
    } result_t;

endpackage

>>> src/i2c_bit_level_master.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                   Payload
// s_        in         s_tvalid / s_tready         s_tdata, s_tuser
// m_        out        m_tvalid / m_tready         m_tdata
// cfg_      in         cfg_valid / cfg_ready       cfg_index, cfg_data
//
// Every input transaction is one bus tick and yields exactly one result, registered and presented in the next cycle.
// One transaction is taken per cycle unless stalled; the single output register sets that rate.
// The input side stalls only while a held result waits on m_tready.
// Reset is synchronous on aresetn and returns the sequencer to idle with both lines released.
// Configuration writes are always accepted and take effect on the next tick.
module i2c_bit_level_master (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // write_data[7:0], more_follow[8], sda_in[9], zero[15:10]
    input  logic [2:0]  s_tuser,   // cmd_valid[0], operation[2:1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // scl_drive_low[0], sda_drive_low[1], ready_res[2],
                                   // done_res[3], ack_seen[4], read_data[12:5], zero[15:13]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import i2cblm_pkg::*;

    cfg_t    cfg_reg;
    tick_t   tick;
    result_t res;
    result_t out_reg;
    logic    out_valid_reg;
    logic    step;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bit_delay          <= BIT_DELAY_RESET;
            cfg_reg.setup_delay        <= SETUP_DELAY_RESET;
            cfg_reg.write_pause_enable <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_BIT_DELAY:   cfg_reg.bit_delay          <= cfg_data;
                REG_SETUP_DELAY: cfg_reg.setup_delay        <= cfg_data;
                REG_WRITE_PAUSE: cfg_reg.write_pause_enable <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign tick.cmd_valid   = s_tuser[0];
    assign tick.operation   = op_t'(s_tuser[2:1]);
    assign tick.write_data  = s_tdata[7:0];
    assign tick.more_follow = s_tdata[8];
    assign tick.sda_in      = s_tdata[9];

    assign s_tready = !out_valid_reg || m_tready;
    assign step     = s_tvalid && s_tready;

    i2cblm_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .cfg     (cfg_reg),
        .tick    (tick),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg};

endmodule

>>> src/i2cblm_seq.sv
`timescale 1ns / 1ps

module i2cblm_seq (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  i2cblm_pkg::cfg_t    cfg,
    input  i2cblm_pkg::tick_t   tick,
    output i2cblm_pkg::result_t res
);
    import i2cblm_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] delay_reg, delay_next;
    logic        scl_low_reg, scl_low_next;
    logic        sda_low_reg, sda_low_next;
    logic        ack_reg, ack_next;
    logic        more_reg, more_next;
    logic [7:0]  last_read_reg, last_read_next;

    logic        done;
    logic        do_enter;
    phase_t      enter_ph;
    logic [15:0] dec;
    logic [3:0]  bit_inc;
    logic [15:0] bit_delay_min;
    logic [15:0] setup_delay_min;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            bit_count_reg <= '0;
            shift_reg     <= '0;
            delay_reg     <= '0;
            scl_low_reg   <= 1'b0;
            sda_low_reg   <= 1'b0;
            ack_reg       <= 1'b0;
            more_reg      <= 1'b0;
            last_read_reg <= '0;
        end else if (step) begin
            phase_reg     <= phase_next;
            bit_count_reg <= bit_count_next;
            shift_reg     <= shift_next;
            delay_reg     <= delay_next;
            scl_low_reg   <= scl_low_next;
            sda_low_reg   <= sda_low_next;
            ack_reg       <= ack_next;
            more_reg      <= more_next;
            last_read_reg <= last_read_next;
        end
    end

    assign bit_delay_min   = (cfg.bit_delay == '0) ? 16'd1 : cfg.bit_delay;
    assign setup_delay_min = (cfg.setup_delay == '0) ? 16'd1 : cfg.setup_delay;
    assign dec             = (delay_reg != '0) ? delay_reg - 16'd1 : delay_reg;
    assign bit_inc         = bit_count_reg + 4'd1;

    always_comb begin
        phase_next     = phase_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        delay_next     = delay_reg;
        scl_low_next   = scl_low_reg;
        sda_low_next   = sda_low_reg;
        ack_next       = ack_reg;
        more_next      = more_reg;
        last_read_next = last_read_reg;
        done           = 1'b0;
        do_enter       = 1'b0;
        enter_ph       = PH_IDLE;

        case (phase_reg)
            PH_IDLE: begin
                if (tick.cmd_valid) begin
                    bit_count_next = '0;
                    more_next      = tick.more_follow;
                    shift_next     = (tick.operation == OP_WRITE) ? tick.write_data : 8'd0;
                    do_enter       = 1'b1;
                    case (tick.operation)
                        OP_START: enter_ph = PH_ST_REL;
                        OP_STOP:  enter_ph = PH_SP_SDA;
                        OP_WRITE: enter_ph = PH_WR_LOW;
                        default:  enter_ph = PH_RD_LOW;
                    endcase
                end
            end
            PH_ST_REL, PH_ST_SDA, PH_SP_SDA, PH_SP_SCL, PH_WR_LOW, PH_WR_HIGH,
            PH_WA_LOW, PH_WA_HIGH, PH_RD_LOW, PH_RD_HIGH, PH_RA_LOW,
            PH_RA_HIGH: begin
                delay_next = dec;
                if (dec == '0) begin
                    case (phase_reg)
                        PH_ST_REL: begin
                            do_enter = 1'b1;
                            enter_ph = PH_ST_SDA;
                        end
                        PH_ST_SDA: begin
                            scl_low_next = 1'b1;
                            phase_next   = PH_IDLE;
                            done         = 1'b1;
                        end
                        PH_SP_SDA: begin
                            do_enter = 1'b1;
                            enter_ph = PH_SP_SCL;
                        end
                        PH_SP_SCL: begin
                            sda_low_next = 1'b0;
                            phase_next   = PH_IDLE;
                            done         = 1'b1;
                        end
                        PH_WR_LOW: begin
                            do_enter = 1'b1;
                            enter_ph = PH_WR_HIGH;
                        end
                        PH_WR_HIGH: begin
                            shift_next     = {shift_reg[6:0], 1'b0};
                            bit_count_next = bit_inc;
                            do_enter       = 1'b1;
                            enter_ph       = (bit_inc >= 4'(BITS_PER_BYTE)) ? PH_WA_LOW
                                                                           : PH_WR_LOW;
                        end
                        PH_WA_LOW: begin
                            do_enter = 1'b1;
                            enter_ph = PH_WA_HIGH;
                        end
                        PH_WA_HIGH: begin
                            ack_next     = ~tick.sda_in;
                            scl_low_next = 1'b1;
                            sda_low_next = ~tick.sda_in;
                            phase_next   = PH_IDLE;
                            done         = 1'b1;
                        end
                        PH_RD_LOW: begin
                            do_enter = 1'b1;
                            enter_ph = PH_RD_HIGH;
                        end
                        PH_RD_HIGH: begin
                            shift_next     = {shift_reg[6:0], tick.sda_in};
                            bit_count_next = bit_inc;
                            do_enter       = 1'b1;
                            enter_ph       = (bit_inc >= 4'(BITS_PER_BYTE)) ? PH_RA_LOW
                                                                           : PH_RD_LOW;
                        end
                        PH_RA_LOW: begin
                            do_enter = 1'b1;
                            enter_ph = PH_RA_HIGH;
                        end
                        default: begin
                            last_read_next = shift_reg;
                            scl_low_next   = 1'b1;
                            phase_next     = PH_IDLE;
                            done           = 1'b1;
                        end
                    endcase
                end
            end
            default: begin
                phase_next = PH_IDLE;
                delay_next = '0;
            end
        endcase

        if (do_enter) begin
            phase_next = enter_ph;
            delay_next = 16'd1;
            case (enter_ph)
                PH_ST_REL: begin
                    scl_low_next = 1'b0;
                    sda_low_next = 1'b0;
                    delay_next   = setup_delay_min;
                end
                PH_ST_SDA: begin
                    sda_low_next = 1'b1;
                    delay_next   = setup_delay_min;
                end
                PH_SP_SDA: begin
                    sda_low_next = 1'b1;
                    delay_next   = setup_delay_min;
                end
                PH_SP_SCL: begin
                    scl_low_next = 1'b0;
                    delay_next   = setup_delay_min;
                end
                PH_WR_LOW: begin
                    scl_low_next = 1'b1;
                    sda_low_next = ~shift_next[7];
                end
                PH_WR_HIGH: begin
                    scl_low_next = 1'b0;
                    if (cfg.write_pause_enable) begin
                        delay_next = bit_delay_min;
                    end
                end
                PH_WA_LOW: begin
                    scl_low_next = 1'b1;
                    sda_low_next = 1'b0;
                end
                PH_WA_HIGH: begin
                    scl_low_next = 1'b0;
                end
                PH_RD_LOW: begin
                    scl_low_next = 1'b1;
                    sda_low_next = 1'b0;
                end
                PH_RD_HIGH: begin
                    scl_low_next = 1'b0;
                    delay_next   = bit_delay_min;
                end
                PH_RA_LOW: begin
                    scl_low_next = 1'b1;
                    sda_low_next = more_next;
                end
                PH_RA_HIGH: begin
                    scl_low_next = 1'b0;
                    if (cfg.write_pause_enable) begin
                        delay_next = bit_delay_min;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                    delay_next = '0;
                end
            endcase
        end else if (phase_next == PH_IDLE && phase_reg != PH_IDLE) begin
            delay_next = '0;
        end
    end

    assign res.scl_drive_low = scl_low_next;
    assign res.sda_drive_low = sda_low_next;
    assign res.ready_res     = (phase_next == PH_IDLE);
    assign res.done_res      = done;
    assign res.ack_seen      = ack_next;
    assign res.read_data     = last_read_next;

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;

    import i2cblm_pkg::*;

    localparam int SDA_LOW  = 0;
    localparam int SDA_HIGH = 1;
    localparam int SDA_RAND = 2;

    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned RANDOM_TICKS = 900;
    localparam int unsigned END_CYCLES   = 10;
    localparam int unsigned CYCLE_LIMIT  = 1_500_000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic [2:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    i2c_bit_level_master i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    // Bus sequencer model, advanced once per accepted transaction.
    cfg_t        bus_cfg;
    phase_t      bus_phase;
    logic [3:0]  bits_done;
    logic [7:0]  shreg;
    logic [15:0] hold_cnt;
    logic        scl_low;
    logic        sda_low;
    logic        ack_bit;
    logic        more_bit;
    logic [7:0]  last_byte;

    result_t     pending_results[$];
    int unsigned errors      = 0;
    int unsigned ticks_sent  = 0;
    int unsigned cycle_count = 0;
    bit          tx_gaps     = 1'b1;
    bit          rx_gaps     = 1'b1;
    bit          hold_req    = 1'b0;

    function automatic logic [15:0] at_least_one(logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    function automatic void enter_phase(phase_t p);
        bus_phase = p;
        hold_cnt  = 16'd1;
        case (p)
            PH_ST_REL: begin
                scl_low  = 1'b0;
                sda_low  = 1'b0;
                hold_cnt = at_least_one(bus_cfg.setup_delay);
            end
            PH_ST_SDA, PH_SP_SDA: begin
                sda_low  = 1'b1;
                hold_cnt = at_least_one(bus_cfg.setup_delay);
            end
            PH_SP_SCL: begin
                scl_low  = 1'b0;
                hold_cnt = at_least_one(bus_cfg.setup_delay);
            end
            PH_WR_LOW: begin
                scl_low = 1'b1;
                sda_low = ~shreg[7];
            end
            PH_WR_HIGH, PH_RA_HIGH: begin
                scl_low = 1'b0;
                if (bus_cfg.write_pause_enable) hold_cnt = at_least_one(bus_cfg.bit_delay);
            end
            PH_WA_LOW, PH_RD_LOW: begin
                scl_low = 1'b1;
                sda_low = 1'b0;
            end
            PH_WA_HIGH: scl_low = 1'b0;
            PH_RD_HIGH: begin
                scl_low  = 1'b0;
                hold_cnt = at_least_one(bus_cfg.bit_delay);
            end
            PH_RA_LOW: begin
                scl_low = 1'b1;
                sda_low = more_bit;
            end
            default: begin
                bus_phase = PH_IDLE;
                hold_cnt  = 16'd0;
            end
        endcase
    endfunction

    function automatic void go_idle();
        bus_phase = PH_IDLE;
        hold_cnt  = 16'd0;
    endfunction

    function automatic result_t bus_tick(tick_t t);
        result_t r;
        logic    done;
        done = 1'b0;
        if (bus_phase == PH_IDLE) begin
            if (t.cmd_valid) begin
                bits_done = 4'd0;
                more_bit  = t.more_follow;
                shreg     = (t.operation == OP_WRITE) ? t.write_data : 8'h00;
                case (t.operation)
                    OP_START: enter_phase(PH_ST_REL);
                    OP_STOP:  enter_phase(PH_SP_SDA);
                    OP_WRITE: enter_phase(PH_WR_LOW);
                    default:  enter_phase(PH_RD_LOW);
                endcase
            end
        end else begin
            if (hold_cnt != 16'd0) hold_cnt = hold_cnt - 16'd1;
            if (hold_cnt == 16'd0) begin
                case (bus_phase)
                    PH_ST_REL: enter_phase(PH_ST_SDA);
                    PH_ST_SDA: begin
                        scl_low = 1'b1;
                        go_idle();
                        done = 1'b1;
                    end
                    PH_SP_SDA: enter_phase(PH_SP_SCL);
                    PH_SP_SCL: begin
                        sda_low = 1'b0;
                        go_idle();
                        done = 1'b1;
                    end
                    PH_WR_LOW: enter_phase(PH_WR_HIGH);
                    PH_WR_HIGH: begin
                        shreg     = shreg << 1;
                        bits_done = bits_done + 4'd1;
                        enter_phase((bits_done >= 4'(BITS_PER_BYTE)) ? PH_WA_LOW : PH_WR_LOW);
                    end
                    PH_WA_LOW: enter_phase(PH_WA_HIGH);
                    PH_WA_HIGH: begin
                        ack_bit = ~t.sda_in;
                        scl_low = 1'b1;
                        sda_low = ack_bit;
                        go_idle();
                        done = 1'b1;
                    end
                    PH_RD_LOW: enter_phase(PH_RD_HIGH);
                    PH_RD_HIGH: begin
                        shreg     = {shreg[6:0], t.sda_in};
                        bits_done = bits_done + 4'd1;
                        enter_phase((bits_done >= 4'(BITS_PER_BYTE)) ? PH_RA_LOW : PH_RD_LOW);
                    end
                    PH_RA_LOW: enter_phase(PH_RA_HIGH);
                    PH_RA_HIGH: begin
                        last_byte = shreg;
                        scl_low   = 1'b1;
                        go_idle();
                        done = 1'b1;
                    end
                    default: go_idle();
                endcase
            end
        end
        r.scl_drive_low = scl_low;
        r.sda_drive_low = sda_low;
        r.ready_res     = (bus_phase == PH_IDLE);
        r.done_res      = done;
        r.ack_seen      = ack_bit;
        r.read_data     = last_byte;
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic sda_level(int sel);
        if (sel == SDA_LOW) return 1'b0;
        if (sel == SDA_HIGH) return 1'b1;
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic report(string what, int unsigned want, int unsigned got);
        $display("ERROR %0t ns: %s expected 0x%0h got 0x%0h", $time, what, want, got);
        errors++;
    endtask

    task automatic send_tick(tick_t t);
        int unsigned n;
        n = tx_gaps ? pick_gap() : 0;
        if (n != 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, t.sda_in, t.more_follow, t.write_data};
        s_tuser  <= {t.operation, t.cmd_valid};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(bus_tick(t));
        ticks_sent++;
    endtask

    task automatic send_idle(int unsigned count);
        tick_t t;
        repeat (count) begin
            t.cmd_valid   = 1'b0;
            t.operation   = op_t'($urandom_range(0, 3));
            t.write_data  = 8'($urandom);
            t.more_follow = 1'($urandom_range(0, 1));
            t.sda_in      = 1'($urandom_range(0, 1));
            send_tick(t);
        end
    endtask

    // Issues one command and keeps ticking until the sequencer is back in idle.
    task automatic run_command(op_t op, logic [7:0] data, logic more, int sda_sel, bit noisy);
        tick_t t;
        t.cmd_valid   = 1'b1;
        t.operation   = op;
        t.write_data  = data;
        t.more_follow = more;
        t.sda_in      = sda_level(sda_sel);
        send_tick(t);
        while (bus_phase != PH_IDLE) begin
            t.cmd_valid   = noisy ? 1'($urandom_range(0, 1)) : 1'b0;
            t.operation   = op_t'($urandom_range(0, 3));
            t.write_data  = 8'($urandom);
            t.more_follow = 1'($urandom_range(0, 1));
            t.sda_in      = sda_level(sda_sel);
            send_tick(t);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_BIT_DELAY:   bus_cfg.bit_delay          = val;
            REG_SETUP_DELAY: bus_cfg.setup_delay        = val;
            REG_WRITE_PAUSE: bus_cfg.write_pause_enable = val[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic reset_model();
        bus_cfg.bit_delay          = BIT_DELAY_RESET;
        bus_cfg.setup_delay        = SETUP_DELAY_RESET;
        bus_cfg.write_pause_enable = 1'b0;
        bus_phase = PH_IDLE;
        bits_done = '0;
        shreg     = '0;
        hold_cnt  = '0;
        scl_low   = 1'b0;
        sda_low   = 1'b0;
        ack_bit   = 1'b0;
        more_bit  = 1'b0;
        last_byte = '0;
    endtask

    task automatic test_reset_defaults();
        run_command(OP_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0);
        send_idle(3);
        run_command(OP_START, 8'h00, 1'b0, SDA_RAND, 1'b0);
        run_command(OP_WRITE, 8'hA5, 1'b0, SDA_LOW, 1'b0);
        run_command(OP_WRITE, 8'h5A, 1'b1, SDA_HIGH, 1'b0);
        run_command(OP_READ, 8'h00, 1'b1, SDA_RAND, 1'b0);
        run_command(OP_READ, 8'h00, 1'b0, SDA_RAND, 1'b0);
        run_command(OP_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0);
        settle();
    endtask

    task automatic test_zero_delays();
        write_reg(REG_BIT_DELAY, 16'd0);
        write_reg(REG_SETUP_DELAY, 16'd0);
        write_reg(REG_WRITE_PAUSE, 16'd1);
        run_command(OP_START, 8'h00, 1'b0, SDA_RAND, 1'b0);
        run_command(OP_WRITE, 8'h00, 1'b0, SDA_LOW, 1'b0);
        run_command(OP_WRITE, 8'hFF, 1'b0, SDA_HIGH, 1'b0);
        run_command(OP_READ, 8'hFF, 1'b1, SDA_LOW, 1'b0);
        run_command(OP_READ, 8'h00, 1'b0, SDA_HIGH, 1'b0);
        run_command(OP_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0);
        settle();
        write_reg(REG_WRITE_PAUSE, 16'd0);
        run_command(OP_START, 8'h00, 1'b0, SDA_RAND, 1'b1);
        run_command(OP_WRITE, 8'h81, 1'b1, SDA_RAND, 1'b1);
        run_command(OP_READ, 8'h00, 1'b1, SDA_RAND, 1'b1);
        run_command(OP_STOP, 8'h00, 1'b0, SDA_RAND, 1'b1);
        settle();
    endtask

    task automatic test_paced_clocks();
        write_reg(REG_BIT_DELAY, 16'd3);
        write_reg(REG_SETUP_DELAY, 16'd1);
        write_reg(REG_WRITE_PAUSE, 16'd1);
        run_command(OP_START, 8'h00, 1'b0, SDA_RAND, 1'b0);
        run_command(OP_WRITE, 8'($urandom), 1'b0, SDA_RAND, 1'b0);
        run_command(OP_READ, 8'h00, 1'b0, SDA_RAND, 1'b0);
        settle();
        write_reg(REG_WRITE_PAUSE, 16'hFFFE);
        write_reg(REG_UNUSED, 16'($urandom));
        run_command(OP_WRITE, 8'($urandom), 1'b0, SDA_RAND, 1'b0);
        run_command(OP_READ, 8'h00, 1'b1, SDA_RAND, 1'b0);
        run_command(OP_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0);
        settle();
    endtask

    task automatic test_long_setup();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        write_reg(REG_SETUP_DELAY, 16'd150);
        run_command(OP_STOP, 8'h00, 1'b0, SDA_RAND, 1'b1);
        settle();
        write_reg(REG_BIT_DELAY, 16'hFFFF);
        write_reg(REG_WRITE_PAUSE, 16'd0);
        run_command(OP_WRITE, 8'($urandom), 1'b0, SDA_RAND, 1'b1);
        settle();
        write_reg(REG_BIT_DELAY, 16'd2);
        write_reg(REG_SETUP_DELAY, 16'd2);
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    task automatic test_backpressure();
        tx_gaps  = 1'b0;
        hold_req = 1'b1;
        run_command(OP_START, 8'h00, 1'b0, SDA_RAND, 1'b1);
        run_command(OP_WRITE, 8'($urandom), 1'b0, SDA_RAND, 1'b1);
        settle();
        tx_gaps = 1'b1;
    endtask

    function automatic logic [15:0] pick_delay();
        if ($urandom_range(0, 9) != 0) return 16'($urandom_range(0, 3));
        return 16'($urandom_range(4, 20));
    endfunction

    task automatic run_frame();
        logic [7:0]  addr;
        int unsigned nbytes;
        bit          noisy;
        noisy = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 9) < 8) begin
            addr   = 8'($urandom);
            nbytes = $urandom_range(1, 3);
            run_command(OP_START, 8'($urandom), 1'($urandom), SDA_RAND, noisy);
            run_command(OP_WRITE, addr, 1'($urandom), SDA_RAND, noisy);
            for (int i = 0; i < nbytes; i++) begin
                if (addr[0]) run_command(OP_READ, 8'($urandom), i != nbytes - 1, SDA_RAND, noisy);
                else run_command(OP_WRITE, 8'($urandom), 1'($urandom), SDA_RAND, noisy);
            end
            run_command(OP_STOP, 8'($urandom), 1'($urandom), SDA_RAND, noisy);
        end else begin
            repeat ($urandom_range(1, 4)) begin
                run_command(op_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
                            SDA_RAND, noisy);
            end
        end
        if ($urandom_range(0, 3) == 0) send_idle($urandom_range(1, 4));
    endtask

    task automatic test_random_traffic();
        int unsigned stop_at;
        stop_at = ticks_sent + RANDOM_TICKS;
        while (ticks_sent < stop_at) begin
            settle();
            write_reg(REG_BIT_DELAY, pick_delay());
            write_reg(REG_SETUP_DELAY, pick_delay());
            write_reg(REG_WRITE_PAUSE, 16'($urandom));
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_gaps = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(2, 5)) run_frame();
        end
        settle();
    endtask

    always begin : result_sink
        int unsigned n;
        @(posedge aclk);
        if (hold_req) begin
            m_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge aclk);
            hold_req = 1'b0;
            m_tready <= 1'b1;
        end else begin
            n = rx_gaps ? pick_gap() : 0;
            if (n != 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        result_t want;
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[12:0]);
            if (pending_results.size() == 0) begin
                report("unexpected result", 0, 32'(m_tdata));
            end else begin
                want = pending_results.pop_front();
                if (got.scl_drive_low !== want.scl_drive_low)
                    report("scl_drive_low", 32'(want.scl_drive_low), 32'(got.scl_drive_low));
                if (got.sda_drive_low !== want.sda_drive_low)
                    report("sda_drive_low", 32'(want.sda_drive_low), 32'(got.sda_drive_low));
                if (got.ready_res !== want.ready_res)
                    report("ready_res", 32'(want.ready_res), 32'(got.ready_res));
                if (got.done_res !== want.done_res)
                    report("done_res", 32'(want.done_res), 32'(got.done_res));
                if (got.ack_seen !== want.ack_seen)
                    report("ack_seen", 32'(want.ack_seen), 32'(got.ack_seen));
                if (got.read_data !== want.read_data)
                    report("read_data", 32'(want.read_data), 32'(got.read_data));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        reset_model();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_zero_delays();
        test_paced_clocks();
        test_long_setup();
        test_backpressure();
        test_random_traffic();
        repeat (END_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            report("results still outstanding", 0, pending_results.size());
        end
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
